### rtl/aat_pkg.sv
// -----------------------------------------------------------------------------
// Alias address table package
// Shared types, sizes and codes for the alias address table.
// -----------------------------------------------------------------------------
package aat_pkg;

    // Table size and the widths that follow from it.
    localparam int TABLE_DEPTH = 32;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    // Fixed field widths.
    localparam int FUNC_W      = 2;
    localparam int ADDR_W      = 32;
    localparam int HEAD_W      = 64;
    localparam int TAIL_W      = 16;
    localparam int STATUS_W    = 3;
    localparam int COUNT_W     = 6;
    localparam int ALIAS_CHARS = 10;
    localparam int ALIAS_W     = HEAD_W + TAIL_W;

    // Operation codes.
    localparam logic [FUNC_W-1:0] FUNC_INSERT   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_LOOKUP   = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_LOCALITY = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_LIST     = 2'd3;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STAT_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_ADDR_DUP  = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_ALIAS_DUP = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_BOTH_DUP  = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_FULL      = 3'd4;
    localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 3'd5;

    // One stored table entry.
    typedef struct packed {
        logic [ADDR_W-1:0] address;
        logic [HEAD_W-1:0] alias_head;
        logic [TAIL_W-1:0] alias_tail;
    } entry_t;

    // A command handed to the scan engine, alias already normalised.
    typedef struct packed {
        logic [FUNC_W-1:0] func;
        entry_t            entry;
    } cmd_t;

    // One result leaving the scan engine.
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        entry_t              entry;
        logic [COUNT_W-1:0]  entry_count;
        logic                last;
    } res_t;

endpackage

### rtl/aat_norm.sv
// -----------------------------------------------------------------------------
// Alias normaliser
// Clears every character after the first zero character and, for an insert,
// folds lower-case letters to upper case.
// -----------------------------------------------------------------------------
module aat_norm
    import aat_pkg::*;
(
    input  logic [FUNC_W-1:0] func,
    input  logic [HEAD_W-1:0] alias_head,
    input  logic [TAIL_W-1:0] alias_tail,
    output logic [HEAD_W-1:0] alias_head_norm,
    output logic [TAIL_W-1:0] alias_tail_norm
);

    logic [ALIAS_W-1:0] alias_in;
    logic [ALIAS_W-1:0] alias_out;
    logic               fold;

    assign alias_in = {alias_head, alias_tail};
    assign fold     = (func == FUNC_INSERT);

    // Walk the characters from the first; the first character sits highest.
    always_comb
    begin
        logic       ended;
        logic [7:0] ch;
        ended     = 1'b0;
        alias_out = '0;
        for (int i = 0; i < ALIAS_CHARS; i++)
        begin
            ch = alias_in[ALIAS_W-1-8*i -: 8];
            if (ended)
            begin
                ch = 8'h00;
            end
            else if (ch == 8'h00)
            begin
                ended = 1'b1;
            end
            if (fold && (ch >= 8'h61) && (ch <= 8'h7a))
            begin
                ch = ch - 8'h20;
            end
            alias_out[ALIAS_W-1-8*i -: 8] = ch;
        end
    end

    assign alias_head_norm = alias_out[ALIAS_W-1:TAIL_W];
    assign alias_tail_norm = alias_out[TAIL_W-1:0];

endmodule

### rtl/aat_scan.sv
// -----------------------------------------------------------------------------
// Alias address table scan engine
// Holds the table in a synchronous memory and walks it newest entry first,
// one read per cycle unless a stalled output holds it, comparing, collecting hits and appending on insert.
// -----------------------------------------------------------------------------
module aat_scan
    import aat_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic cmd_valid,
    output logic cmd_ready,
    input  cmd_t cmd,
    output logic res_valid,
    input  logic res_ready,
    output res_t res
);

    // Sequencer states.
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic [CNT_W-1:0] remain_reg, remain_next;
    logic             dv_reg, dv_next;
    logic             addr_dup_reg, addr_dup_next;
    logic             alias_dup_reg, alias_dup_next;
    logic             pend_valid_reg, pend_valid_next;
    logic             out_valid_reg, out_valid_next;
    cmd_t             cmd_reg;
    entry_t           pend_reg;
    res_t             out_reg;

    // Table memory.
    entry_t           mem [TABLE_DEPTH];
    entry_t           rd_data_reg;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;

    logic             can_out;
    logic             addr_hit;
    logic             alias_hit;
    logic             loc_hit;
    logic             match;
    logic             hit;
    logic             stall;
    logic             pend_load;
    logic             out_load;
    res_t             out_data;

    assign cmd_ready = (state_reg == S_IDLE);
    assign res_valid = out_valid_reg;
    assign res       = out_reg;

    // Compare the entry held in the read register against the command.
    assign addr_hit  = (rd_data_reg.address == cmd_reg.entry.address);
    assign alias_hit = (rd_data_reg.alias_head == cmd_reg.entry.alias_head)
                    && (rd_data_reg.alias_tail == cmd_reg.entry.alias_tail);
    assign loc_hit   = (rd_data_reg.address[ADDR_W-1:16]
                        == cmd_reg.entry.address[ADDR_W-1:16]);

    always_comb
    begin
        case (cmd_reg.func)
            FUNC_LOOKUP:   match = alias_hit;
            FUNC_LOCALITY: match = loc_hit;
            FUNC_LIST:     match = 1'b1;
            default:       match = 1'b0;
        endcase
    end

    // A new hit pushes the held hit out, which needs room in the output register.
    assign can_out = !out_valid_reg || res_ready;
    assign hit     = dv_reg && match;
    assign stall   = hit && pend_valid_reg && !can_out;
    assign rd_addr = IDX_W'(remain_reg - CNT_W'(1));
    assign wr_addr = IDX_W'(fill_reg);

    // Sequencer.
    always_comb
    begin
        state_next      = state_reg;
        fill_next       = fill_reg;
        remain_next     = remain_reg;
        dv_next         = dv_reg;
        addr_dup_next   = addr_dup_reg;
        alias_dup_next  = alias_dup_reg;
        pend_valid_next = pend_valid_reg;
        rd_en           = 1'b0;
        wr_en           = 1'b0;
        pend_load       = 1'b0;
        out_load        = 1'b0;
        out_data        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    state_next      = S_SCAN;
                    remain_next     = fill_reg;
                    dv_next         = 1'b0;
                    addr_dup_next   = 1'b0;
                    alias_dup_next  = 1'b0;
                    pend_valid_next = 1'b0;
                end
            end
            S_SCAN:
            begin
                if (!dv_reg && (remain_reg == '0))
                begin
                    state_next = S_DONE;
                end
                else if (!stall)
                begin
                    if (dv_reg && (cmd_reg.func == FUNC_INSERT))
                    begin
                        addr_dup_next  = addr_dup_reg | addr_hit;
                        alias_dup_next = alias_dup_reg | alias_hit;
                    end
                    if (hit)
                    begin
                        pend_load       = 1'b1;
                        pend_valid_next = 1'b1;
                        if (pend_valid_reg)
                        begin
                            out_load             = 1'b1;
                            out_data.status      = STAT_OK;
                            out_data.entry       = pend_reg;
                            out_data.entry_count = COUNT_W'(fill_reg);
                            out_data.last        = 1'b0;
                        end
                    end
                    rd_en   = (remain_reg != '0);
                    dv_next = (remain_reg != '0);
                    if (remain_reg != '0)
                    begin
                        remain_next = remain_reg - CNT_W'(1);
                    end
                end
            end
            S_DONE:
            begin
                if (can_out)
                begin
                    out_load      = 1'b1;
                    out_data.last = 1'b1;
                    state_next    = S_IDLE;
                    if (cmd_reg.func == FUNC_INSERT)
                    begin
                        out_data.entry = cmd_reg.entry;
                        if (addr_dup_reg && alias_dup_reg)
                        begin
                            out_data.status = STAT_BOTH_DUP;
                        end
                        else if (addr_dup_reg)
                        begin
                            out_data.status = STAT_ADDR_DUP;
                        end
                        else if (alias_dup_reg)
                        begin
                            out_data.status = STAT_ALIAS_DUP;
                        end
                        else if (fill_reg == CNT_W'(TABLE_DEPTH))
                        begin
                            out_data.status = STAT_FULL;
                        end
                        else
                        begin
                            out_data.status = STAT_OK;
                            wr_en           = 1'b1;
                            fill_next       = fill_reg + CNT_W'(1);
                        end
                        out_data.entry_count = COUNT_W'(fill_next);
                    end
                    else
                    begin
                        out_data.entry_count = COUNT_W'(fill_reg);
                        if (pend_valid_reg)
                        begin
                            out_data.status = STAT_OK;
                            out_data.entry  = pend_reg;
                        end
                        else
                        begin
                            out_data.status = STAT_NOT_FOUND;
                        end
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (res_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            fill_reg       <= '0;
            remain_reg     <= '0;
            dv_reg         <= 1'b0;
            addr_dup_reg   <= 1'b0;
            alias_dup_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            fill_reg       <= fill_next;
            remain_reg     <= remain_next;
            dv_reg         <= dv_next;
            addr_dup_reg   <= addr_dup_next;
            alias_dup_reg  <= alias_dup_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd_valid && cmd_ready)
        begin
            cmd_reg <= cmd;
        end
        if (pend_load)
        begin
            pend_reg <= rd_data_reg;
        end
        if (out_load)
        begin
            out_reg <= out_data;
        end
    end

    // Table memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= cmd_reg.entry;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

endmodule

### rtl/alias_address_table_top.sv
// -----------------------------------------------------------------------------
// Alias address table
// Maps IPv4 addresses to aliases of up to ten characters: insert, lookup by
// alias, locality query on the first two octets and list, newest entry first.
//
//   Channel   Direction  tdata (low bit up)                        tuser    tlast
//   s_axis    in         address, alias_head, alias_tail           func     -
//   m_axis    out        address_out, alias_head_out,              status   last
//                        alias_tail_out, entry_count, zero pad
//
// Unstalled, one table entry is read per cycle, and the next transaction is taken
// once the final result sits in the output register.
// Reset empties the table at once; no clearing pass is needed.
// A stalled output halts the scan when a second hit finds the output full.
// -----------------------------------------------------------------------------
module alias_address_table_top
    import aat_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [111:0] s_tdata,   // address, alias_head, alias_tail
    input  logic [1:0]   s_tuser,   // func
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [119:0] m_tdata,   // address_out, alias_head_out, alias_tail_out,
                                    // entry_count, two zero bits
    output logic [2:0]   m_tuser,   // status
    output logic         m_tlast    // last
);

    cmd_t              cmd;
    res_t              res;
    logic [HEAD_W-1:0] head_norm;
    logic [TAIL_W-1:0] tail_norm;

    // Normalise the incoming alias.
    aat_norm u_norm
    (
        .func            (s_tuser),
        .alias_head      (s_tdata[95:32]),
        .alias_tail      (s_tdata[111:96]),
        .alias_head_norm (head_norm),
        .alias_tail_norm (tail_norm)
    );

    assign cmd.func             = s_tuser;
    assign cmd.entry.address    = s_tdata[31:0];
    assign cmd.entry.alias_head = head_norm;
    assign cmd.entry.alias_tail = tail_norm;

    // Table and scan engine.
    aat_scan u_scan
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (s_tvalid),
        .cmd_ready (s_tready),
        .cmd       (cmd),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .res       (res)
    );

    // Pack the result transaction.
    assign m_tdata = {2'b00, res.entry_count, res.entry.alias_tail,
                      res.entry.alias_head, res.entry.address};
    assign m_tuser = res.status;
    assign m_tlast = res.last;

`ifndef NO_ASSERTIONS
    // An accepted transaction closes the input in the following cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted twice in a row");

    // Only the final result of an operation may carry a status other than ok.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tlast |-> m_tuser == STAT_OK)
        else $error("non-final result with a failure status");

    // A miss is always a single, final result.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == STAT_NOT_FOUND |-> m_tlast)
        else $error("not-found result is not final");

    // The reported count never exceeds the table size.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[117:112] <= COUNT_W'(TABLE_DEPTH))
        else $error("entry count beyond table depth");
`endif

endmodule
